FILE: hdl/assert_macros.svh
// assertion macros shared by the muscle shape integrator rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is held
`define MSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// overlapped implication on top of the plain form
`define MSI_ASSERT_IMP(lbl, ante, cons, msg) \
  `MSI_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: hdl/msi_pkg.sv
// shared types, constants, helpers and the control program of the shape integrator
// no dependencies
`default_nettype none

package msi_pkg;

  // default parameter values
  localparam int STEP_SHIFT_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;

  // activation commands are q1.16 whatever the fraction width
  localparam int CMD_BITS = 16;
  localparam int CMD_W    = 17;
  localparam logic [CMD_W-1:0] CMD_FULL = CMD_W'(65536);

  // datapath widths
  localparam int MUL_W  = 34;
  localparam int WIDE_W = 2 * MUL_W;

  typedef logic signed [31:0]       s32_t;
  typedef logic signed [32:0]       s33_t;
  typedef logic signed [33:0]       s34_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STIFF_LONG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STIFF_CROSS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REST_LONG    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REST_CROSS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT      = 3'd7;

  // register reset values
  localparam logic [31:0] INV_MASS_RST = 32'd65536;
  localparam logic [30:0] REST_RST     = 31'd65536;

  // saturation limits
  localparam wide_t SAT_HI = wide_t'(64'sd2147483647);
  localparam wide_t SAT_LO = wide_t'(-64'sd2147483648);

  // channel payloads
  typedef struct packed {
    logic [CMD_W-1:0] drive_long;
    logic [CMD_W-1:0] drive_cross;
  } in_t;

  typedef struct packed {
    logic signed [31:0] length_long_out;
    logic signed [31:0] length_cross_out;
    logic signed [31:0] rate_long_out;
    logic signed [31:0] rate_cross_out;
  } out_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MS_NONE,
    MS_PUSH,
    MS_ACTIVE,
    MS_SPRING,
    MS_DAMP,
    MS_MASS
  } mul_sel_e;

  // datapath write operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_NET,
    OP_LOAD,
    OP_SUB,
    OP_FORCE,
    OP_ACC,
    OP_HALF_R,
    OP_RATE,
    OP_HALF_L,
    OP_LEN
  } op_e;

  // sequencing: next step, or end of one axis pass
  typedef enum logic {
    SQ_NEXT,
    SQ_AXIS_END
  } seq_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    op_e      op;
    seq_e     seq;
  } ucode_t;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] LAST_PC = 4'd12;

  // one axis pass; a product issued in a step is read in the next one
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uc;
    uc = '{mul_sel: MS_NONE, op: OP_NOP, seq: SQ_NEXT};
    unique case (pc)
      4'd0:  uc.mul_sel = MS_PUSH;
      4'd1:  uc.op = OP_NET;
      4'd2:  uc.mul_sel = MS_ACTIVE;
      4'd3:  uc = '{mul_sel: MS_SPRING, op: OP_LOAD, seq: SQ_NEXT};
      4'd4:  uc = '{mul_sel: MS_DAMP, op: OP_SUB, seq: SQ_NEXT};
      4'd5:  uc.op = OP_SUB;
      4'd6:  uc.op = OP_FORCE;
      4'd7:  uc.mul_sel = MS_MASS;
      4'd8:  uc.op = OP_ACC;
      4'd9:  uc.op = OP_HALF_R;
      4'd10: uc.op = OP_RATE;
      4'd11: uc.op = OP_HALF_L;
      4'd12: uc = '{mul_sel: MS_NONE, op: OP_LEN, seq: SQ_AXIS_END};
      default: uc = '{mul_sel: MS_NONE, op: OP_NOP, seq: SQ_AXIS_END};
    endcase
    return uc;
  endfunction

  // clamp to the signed 32-bit range
  function automatic s32_t sat32(input wide_t v);
    s32_t r;
    if (v > SAT_HI) begin
      r = s32_t'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = s32_t'(SAT_LO);
    end else begin
      r = s32_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/msi_mul.sv
// shared signed multiplier with registered product
// depends on msi_pkg
`default_nettype none

module msi_mul (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire msi_pkg::s34_t a_i,
  input  wire msi_pkg::s34_t b_i,
  output msi_pkg::wide_t     p_o
);
  import msi_pkg::*;

  wide_t p_q;
  wide_t p_d;

  // full-width signed product
  always_comb begin
    p_d = wide_t'(a_i) * wide_t'(b_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: hdl/muscle_shape_integrator.sv
// Two-axis muscle shape integrator. Each accepted item is one time step: the
// two activation commands drive a trapezoidal mass-spring-damper update of the
// long and cross box lengths, and one result item carries the new lengths and
// rates. A 13-step control program runs once per axis on one shared 34x34
// multiplier; a new item is taken only once the block is no longer busy with
// the last one. The finished item sits in an output register; the next item
// is accepted while it waits, and only the final step stalls if that register
// is still full. Configuration may be written only while no item is in
// flight; writing a rest length also reloads that axis length. Depends on
// msi_pkg, msi_mul and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module muscle_shape_integrator #(
  parameter int STEP_SHIFT = msi_pkg::STEP_SHIFT_DEF,
  parameter int FRAC_BITS  = msi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire msi_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output msi_pkg::out_t                      out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [msi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]                   cfg_data_i
);
  import msi_pkg::*;

  // configuration
  logic [31:0] inv_mass_q, stiff_long_q, stiff_cross_q, damping_q;
  logic [30:0] rest_long_q, rest_cross_q;
  logic [31:0] drive_q, ambient_q;

  // integrator state
  s32_t len_long_q, len_cross_q, rate_long_q, rate_cross_q;
  s32_t aprev_long_q, aprev_cross_q;

  // sequencer
  logic            busy_q, axis_q, out_valid_q;
  logic [PC_W-1:0] pc_q;
  ucode_t          uc;
  logic            fire, finish, in_acc;

  // datapath temporaries
  logic [CMD_W-1:0] cmd_long_q, cmd_cross_q;
  s33_t  net_q, dif_q, h_q;
  s34_t  sum_q;
  s32_t  force_q, accn_q, rnew_q, lnl_q;
  out_t  out_data_q;

  // per-axis selections
  logic [CMD_W-1:0] cmd_cur;
  logic [31:0]      stiff_cur;
  logic [30:0]      rest_cur;
  s32_t  len_cur, len_opp, rate_cur, aprev_cur;

  // multiplier
  s34_t  mul_a, mul_b;
  wide_t prod;
  wide_t prod_shr;
  s32_t  frac;
  logic [32:0] push;
  s34_t  net_full;
  s33_t  dif_new, half_r, half_l;
  s32_t  len_new;

  // control program fetch
  always_comb begin
    uc = ucode_rom(pc_q);
  end

  assign in_acc = in_valid_i && !busy_q;
  assign fire   = busy_q && !(uc.seq == SQ_AXIS_END && axis_q && out_valid_q && out_stall_i);
  assign finish = fire && uc.seq == SQ_AXIS_END && axis_q;

  // step counter, axis bit and conditional jump at the end of a pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      axis_q <= 1'b0;
      pc_q   <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      axis_q <= 1'b0;
      pc_q   <= '0;
    end else if (fire) begin
      unique case (uc.seq)
        SQ_NEXT: pc_q <= pc_q + PC_W'(1);
        SQ_AXIS_END: begin
          pc_q <= '0;
          if (axis_q) begin
            busy_q <= 1'b0;
          end else begin
            axis_q <= 1'b1;
          end
        end
      endcase
    end
  end

  // output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // axis operand selection
  always_comb begin
    if (axis_q) begin
      cmd_cur   = cmd_cross_q;
      stiff_cur = stiff_cross_q;
      rest_cur  = rest_cross_q;
      len_cur   = len_cross_q;
      len_opp   = len_long_q;
      rate_cur  = rate_cross_q;
      aprev_cur = aprev_cross_q;
    end else begin
      cmd_cur   = cmd_long_q;
      stiff_cur = stiff_long_q;
      rest_cur  = rest_long_q;
      len_cur   = len_long_q;
      len_opp   = len_cross_q;
      rate_cur  = rate_long_q;
      aprev_cur = aprev_long_q;
    end
  end

  // multiplier operand mux
  always_comb begin
    unique case (uc.mul_sel)
      MS_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MS_PUSH: begin
        mul_a = s34_t'({17'b0, cmd_cur});
        mul_b = s34_t'({2'b0, drive_q});
      end
      MS_ACTIVE: begin
        mul_a = s34_t'(net_q);
        mul_b = s34_t'(len_opp);
      end
      MS_SPRING: begin
        mul_a = s34_t'({2'b0, stiff_cur});
        mul_b = s34_t'(dif_q);
      end
      MS_DAMP: begin
        mul_a = s34_t'({2'b0, damping_q});
        mul_b = s34_t'(rate_cur);
      end
      MS_MASS: begin
        mul_a = s34_t'(force_q);
        mul_b = s34_t'({2'b0, inv_mass_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  msi_mul u_mul (
    .clk_i (clk_i),
    .en_i  (uc.mul_sel != MS_NONE && fire),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // product scaling and the narrow adders of each step
  always_comb begin
    prod_shr = prod >>> FRAC_BITS;
    frac     = sat32(prod_shr);
    push     = prod[CMD_BITS +: 33];
    net_full = $signed({1'b0, push}) - $signed({2'b0, ambient_q});
    dif_new  = s33_t'(len_cur) - $signed({2'b0, rest_cur});
    half_r   = (s33_t'(accn_q) + s33_t'(aprev_cur)) >>> (STEP_SHIFT + 1);
    half_l   = (s33_t'(rnew_q) + s33_t'(rate_cur)) >>> (STEP_SHIFT + 1);
    len_new  = sat32(wide_t'(s34_t'(len_cur) + s34_t'(h_q)));
  end

  // command capture and datapath temporaries
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_long_q  <= (in_data_i.drive_long > CMD_FULL) ? CMD_FULL : in_data_i.drive_long;
      cmd_cross_q <= (in_data_i.drive_cross > CMD_FULL) ? CMD_FULL : in_data_i.drive_cross;
    end
    if (fire) begin
      unique case (uc.op)
        OP_NOP: ;
        OP_NET: begin
          net_q <= net_full[32:0];
          dif_q <= dif_new;
        end
        OP_LOAD:  sum_q   <= s34_t'(frac);
        OP_SUB:   sum_q   <= sum_q - s34_t'(frac);
        OP_FORCE: force_q <= sat32(wide_t'(sum_q));
        OP_ACC:   accn_q  <= frac;
        OP_HALF_R: h_q    <= half_r;
        OP_RATE:  rnew_q  <= sat32(wide_t'(s34_t'(rate_cur) + s34_t'(h_q)));
        OP_HALF_L: h_q    <= half_l;
        OP_LEN: begin
          if (!axis_q) begin
            lnl_q <= len_new;
          end else begin
            out_data_q.length_long_out  <= lnl_q;
            out_data_q.length_cross_out <= len_new;
            out_data_q.rate_long_out    <= rate_long_q;
            out_data_q.rate_cross_out   <= rnew_q;
          end
        end
        default: ;
      endcase
    end
  end

  // configuration registers and integrator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q    <= INV_MASS_RST;
      stiff_long_q  <= '0;
      stiff_cross_q <= '0;
      damping_q     <= '0;
      rest_long_q   <= REST_RST;
      rest_cross_q  <= REST_RST;
      drive_q       <= '0;
      ambient_q     <= '0;
      len_long_q    <= s32_t'({1'b0, REST_RST});
      len_cross_q   <= s32_t'({1'b0, REST_RST});
      rate_long_q   <= '0;
      rate_cross_q  <= '0;
      aprev_long_q  <= '0;
      aprev_cross_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INV_MASS:    inv_mass_q    <= cfg_data_i;
        REG_STIFF_LONG:  stiff_long_q  <= cfg_data_i;
        REG_STIFF_CROSS: stiff_cross_q <= cfg_data_i;
        REG_DAMPING:     damping_q     <= cfg_data_i;
        REG_REST_LONG: begin
          rest_long_q <= cfg_data_i[30:0];
          len_long_q  <= s32_t'({1'b0, cfg_data_i[30:0]});
        end
        REG_REST_CROSS: begin
          rest_cross_q <= cfg_data_i[30:0];
          len_cross_q  <= s32_t'({1'b0, cfg_data_i[30:0]});
        end
        REG_DRIVE:       drive_q       <= cfg_data_i;
        REG_AMBIENT:     ambient_q     <= cfg_data_i;
      endcase
    end else if (fire) begin
      // previous acceleration, rate, and both lengths at the very end
      if (uc.op == OP_HALF_R) begin
        if (axis_q) begin
          aprev_cross_q <= accn_q;
        end else begin
          aprev_long_q <= accn_q;
        end
      end
      if (uc.op == OP_LEN) begin
        if (axis_q) begin
          rate_cross_q <= rnew_q;
          len_long_q   <= lnl_q;
          len_cross_q  <= len_new;
        end else begin
          rate_long_q <= rnew_q;
        end
      end
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // sequencer checks
  `MSI_ASSERT_IMP(a_done_at_end, $fell(busy_q), $past(pc_q == LAST_PC && axis_q), "early item end")
  `MSI_ASSERT_IMP(a_out_from_seq, $rose(out_valid_q), $fell(busy_q), "result without an item")
  `MSI_ASSERT_IMP(a_pc_range, busy_q, pc_q <= LAST_PC, "step counter left the program")

endmodule

`default_nettype wire
